// ===== design/vts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vts_pkg
// Shared types and constants of the volume trilinear sampler.
// ---------------------------------------------------------------------------
package vts_pkg;

    localparam int DIM_MAX         = 32;
    localparam int DIM_BITS        = $clog2(DIM_MAX);
    localparam int SIZE_W          = 6;
    localparam int VALUE_BITS      = 16;
    localparam int COORD_W         = 16;
    localparam int COORD_FRAC_BITS = 14;
    localparam int FRAC_W          = COORD_FRAC_BITS + 1;
    localparam int POS_W           = FRAC_W + DIM_BITS;
    localparam int WEIGHT_W        = FRAC_W + 1;
    localparam int ADDR_W          = 3 * DIM_BITS;
    localparam int VOXEL_COUNT     = DIM_MAX * DIM_MAX * DIM_MAX;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = WEIGHT_W'(1) << FRAC_W;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOCATE,
        ST_ISSUE,
        ST_NEAR,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] base;
        logic [DIM_BITS-1:0] next;
        logic [FRAC_W-1:0]   frac;
    } locate_t;

    typedef struct packed {
        logic                valid;
        logic [WEIGHT_W-1:0] wu;
        logic [WEIGHT_W-1:0] wv;
        logic [WEIGHT_W-1:0] ww;
    } blend_issue_t;

endpackage
`default_nettype wire

// ===== design/vts_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vts_ram
// Generic RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module vts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/vts_locate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vts_locate
// Maps one normalized coordinate to base voxel, clamped neighbor and fraction.
// ---------------------------------------------------------------------------
module vts_locate (
    input  wire logic signed [vts_pkg::COORD_W-1:0] coord,
    input  wire logic        [vts_pkg::SIZE_W-1:0]  size,
    output vts_pkg::locate_t                        loc
);

    localparam logic signed [vts_pkg::COORD_W:0] ONE =
        (vts_pkg::COORD_W+1)'(1) <<< vts_pkg::COORD_FRAC_BITS;
    localparam logic signed [vts_pkg::COORD_W:0] TWO = ONE <<< 1;

    logic signed [vts_pkg::COORD_W:0]    shifted;
    logic        [vts_pkg::FRAC_W:0]     clamped;
    logic        [vts_pkg::SIZE_W-1:0]   eff;
    logic        [vts_pkg::DIM_BITS-1:0] size_m1;
    logic        [vts_pkg::POS_W-1:0]    pos;

    always_comb
    begin
        shifted = (vts_pkg::COORD_W+1)'(coord) + ONE;
        // clamp to [0, 1] in the doubled scale
        if (shifted < 0)
            clamped = '0;
        else if (shifted > TWO)
            clamped = (vts_pkg::FRAC_W+1)'(TWO);
        else
            clamped = (vts_pkg::FRAC_W+1)'(shifted);

        eff = (size > vts_pkg::SIZE_W'(vts_pkg::DIM_MAX)) ?
              vts_pkg::SIZE_W'(vts_pkg::DIM_MAX) : size;
        size_m1 = vts_pkg::DIM_BITS'(eff - vts_pkg::SIZE_W'(1));

        pos = vts_pkg::POS_W'(clamped) * vts_pkg::POS_W'(size_m1);

        loc.base = pos[vts_pkg::POS_W-1:vts_pkg::FRAC_W];
        loc.frac = pos[vts_pkg::FRAC_W-1:0];
        loc.next = (loc.base < size_m1) ? loc.base + vts_pkg::DIM_BITS'(1) : loc.base;
    end

endmodule
`default_nettype wire

// ===== design/vts_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vts_blend
// Weight and product pipeline that accumulates the eight weighted voxels.
// ---------------------------------------------------------------------------
module vts_blend (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  clear,
    input  wire vts_pkg::blend_issue_t                 issue,
    input  wire logic signed [vts_pkg::VALUE_BITS-1:0] rd_data,
    output logic                                       busy,
    output logic signed [vts_pkg::VALUE_BITS-1:0]      result
);

    localparam int UV_W   = 2 * vts_pkg::WEIGHT_W - 1;
    localparam int W3_W   = 3 * vts_pkg::FRAC_W + 1;
    localparam int LO_W   = (W3_W + 1) / 2;
    localparam int HI_W   = W3_W - LO_W;
    localparam int PART_W = vts_pkg::VALUE_BITS + LO_W + 1;
    localparam int ACC_W  = vts_pkg::VALUE_BITS + W3_W + 2;
    localparam int SHIFT  = 3 * vts_pkg::FRAC_W;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (SHIFT - 1);

    logic                                  a_valid_reg, b_valid_reg, c_valid_reg;
    logic [UV_W-1:0]                       uv_reg;
    logic [vts_pkg::WEIGHT_W-1:0]          ww_reg;
    logic [W3_W-1:0]                       w3_reg;
    logic signed [vts_pkg::VALUE_BITS-1:0] vox_reg;
    logic signed [PART_W-1:0]              pl_reg, ph_reg;
    logic signed [ACC_W-1:0]               acc_reg;

    logic [2*vts_pkg::WEIGHT_W-1:0]        uv_next;
    logic [UV_W+vts_pkg::WEIGHT_W-1:0]     w3_full;
    logic signed [LO_W:0]                  lo_s;
    logic signed [HI_W:0]                  hi_s;
    logic signed [PART_W-1:0]              pl_next, ph_next;
    logic signed [ACC_W-1:0]               term, rounded;

    always_comb
    begin
        uv_next = issue.wu * issue.wv;
        w3_full = uv_reg * ww_reg;
        lo_s    = {1'b0, w3_reg[LO_W-1:0]};
        hi_s    = {1'b0, w3_reg[W3_W-1:LO_W]};
        pl_next = vox_reg * lo_s;
        ph_next = vox_reg * hi_s;
        term    = (ACC_W'(ph_reg) <<< LO_W) + ACC_W'(pl_reg);
        rounded = acc_reg + ROUND_HALF;
        result  = rounded[SHIFT+vts_pkg::VALUE_BITS-1:SHIFT];
        busy    = a_valid_reg | b_valid_reg | c_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= issue.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        uv_reg  <= uv_next[UV_W-1:0];
        ww_reg  <= issue.ww;
        w3_reg  <= w3_full[W3_W-1:0];
        vox_reg <= rd_data;
        pl_reg  <= pl_next;
        ph_reg  <= ph_next;
        if (clear)
            acc_reg <= '0;
        else if (c_valid_reg)
            acc_reg <= acc_reg + term;
    end

endmodule
`default_nettype wire

// ===== design/volume_trilinear_sampler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// volume_trilinear_sampler_core
// 32x32x32 voxel volume with nearest and trilinear sampling.
// ---------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  item     item_valid/item_ready  opcode, voxel_x/y/z, voxel_value,
//                                  coord_u/v/w, nearest
//  result   result_valid/ready     sample_value
//  config   cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  A write item never leaves the idle state; an empty-volume sample goes straight
//  to the finish state. A nearest sample makes one read, a trilinear sample eight
//  reads on the single voxel memory read port plus the 3-stage weight/product pipeline.
//  Reset clears the sizes and control; voxel contents stay undefined until
//  written. A waiting result blocks only the next sample's final step.
// ---------------------------------------------------------------------------
module volume_trilinear_sampler_core (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      item_valid,
    output logic                                           item_ready,
    input  wire logic                                      opcode,
    input  wire logic [vts_pkg::DIM_BITS-1:0]              voxel_x,
    input  wire logic [vts_pkg::DIM_BITS-1:0]              voxel_y,
    input  wire logic [vts_pkg::DIM_BITS-1:0]              voxel_z,
    input  wire logic signed [vts_pkg::VALUE_BITS-1:0]     voxel_value,
    input  wire logic signed [vts_pkg::COORD_W-1:0]        coord_u,
    input  wire logic signed [vts_pkg::COORD_W-1:0]        coord_v,
    input  wire logic signed [vts_pkg::COORD_W-1:0]        coord_w,
    input  wire logic                                      nearest,
    output logic                                           result_valid,
    input  wire logic                                      result_ready,
    output logic signed [vts_pkg::VALUE_BITS-1:0]          sample_value,
    input  wire logic                                      cfg_valid,
    output logic                                           cfg_ready,
    input  wire logic [vts_pkg::CFG_INDEX_W-1:0]           cfg_index,
    input  wire logic [vts_pkg::SIZE_W-1:0]                cfg_data
);

    vts_pkg::state_t                       state_reg, state_next;
    logic [vts_pkg::SIZE_W-1:0]            size_x_reg, size_y_reg, size_z_reg;
    logic signed [vts_pkg::COORD_W-1:0]    u_reg, v_reg, w_reg;
    logic                                  nearest_reg;
    vts_pkg::locate_t                      loc_x_reg, loc_y_reg, loc_z_reg;
    vts_pkg::locate_t                      loc_x, loc_y, loc_z;
    logic [2:0]                            corner_reg, corner_next;
    logic signed [vts_pkg::VALUE_BITS-1:0] res_reg, res_next;
    logic                                  res_load;
    logic                                  result_valid_reg, result_valid_next;
    logic signed [vts_pkg::VALUE_BITS-1:0] sample_value_reg;
    logic                                  out_load;

    logic                                  item_take, empty, ram_we, blend_clear, blend_busy;
    logic [vts_pkg::ADDR_W-1:0]            waddr, raddr;
    logic signed [vts_pkg::VALUE_BITS-1:0] rdata, blend_result;
    logic [vts_pkg::DIM_BITS-1:0]          sel_x, sel_y, sel_z;
    vts_pkg::blend_issue_t                 issue;

    assign item_ready   = (state_reg == vts_pkg::ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign sample_value = sample_value_reg;
    assign item_take    = item_valid & item_ready;
    assign empty        = (size_x_reg == '0) | (size_y_reg == '0) | (size_z_reg == '0);
    assign ram_we       = item_take & (opcode == vts_pkg::OP_WRITE);
    assign waddr        = {voxel_z, voxel_y, voxel_x};

    vts_locate u_loc_x (.coord(u_reg), .size(size_x_reg), .loc(loc_x));
    vts_locate u_loc_y (.coord(v_reg), .size(size_y_reg), .loc(loc_y));
    vts_locate u_loc_z (.coord(w_reg), .size(size_z_reg), .loc(loc_z));

    vts_ram #(
        .WIDTH(vts_pkg::VALUE_BITS),
        .DEPTH(vts_pkg::VOXEL_COUNT)
    ) u_voxel_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(waddr),
        .wdata(voxel_value),
        .raddr(raddr),
        .rdata(rdata)
    );

    vts_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (blend_clear),
        .issue  (issue),
        .rd_data(rdata),
        .busy   (blend_busy),
        .result (blend_result)
    );

    // corner bits: [2] x neighbor, [1] y neighbor, [0] z neighbor
    always_comb
    begin
        if (nearest_reg)
        begin
            sel_x = loc_x_reg.frac[vts_pkg::FRAC_W-1] ? loc_x_reg.next : loc_x_reg.base;
            sel_y = loc_y_reg.frac[vts_pkg::FRAC_W-1] ? loc_y_reg.next : loc_y_reg.base;
            sel_z = loc_z_reg.frac[vts_pkg::FRAC_W-1] ? loc_z_reg.next : loc_z_reg.base;
        end
        else
        begin
            sel_x = corner_reg[2] ? loc_x_reg.next : loc_x_reg.base;
            sel_y = corner_reg[1] ? loc_y_reg.next : loc_y_reg.base;
            sel_z = corner_reg[0] ? loc_z_reg.next : loc_z_reg.base;
        end
        raddr = {sel_z, sel_y, sel_x};

        issue.valid = 1'b0;
        issue.wu = corner_reg[2] ? {1'b0, loc_x_reg.frac}
                                 : vts_pkg::WEIGHT_FULL - {1'b0, loc_x_reg.frac};
        issue.wv = corner_reg[1] ? {1'b0, loc_y_reg.frac}
                                 : vts_pkg::WEIGHT_FULL - {1'b0, loc_y_reg.frac};
        issue.ww = corner_reg[0] ? {1'b0, loc_z_reg.frac}
                                 : vts_pkg::WEIGHT_FULL - {1'b0, loc_z_reg.frac};

        state_next  = state_reg;
        corner_next = corner_reg;
        res_next    = res_reg;
        res_load    = 1'b0;
        blend_clear = 1'b0;
        out_load    = 1'b0;

        unique case (state_reg)
            vts_pkg::ST_IDLE:
            begin
                if (item_take && (opcode == vts_pkg::OP_SAMPLE))
                begin
                    if (empty)
                    begin
                        res_next   = '0;
                        res_load   = 1'b1;
                        state_next = vts_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = vts_pkg::ST_LOCATE;
                    end
                end
            end
            vts_pkg::ST_LOCATE:
            begin
                blend_clear = 1'b1;
                corner_next = '0;
                state_next  = vts_pkg::ST_ISSUE;
            end
            vts_pkg::ST_ISSUE:
            begin
                if (nearest_reg)
                begin
                    state_next = vts_pkg::ST_NEAR;
                end
                else
                begin
                    issue.valid = 1'b1;
                    corner_next = corner_reg + 3'd1;
                    if (corner_reg == 3'd7)
                        state_next = vts_pkg::ST_DRAIN;
                end
            end
            vts_pkg::ST_NEAR:
            begin
                res_next   = rdata;
                res_load   = 1'b1;
                state_next = vts_pkg::ST_FINISH;
            end
            vts_pkg::ST_DRAIN:
            begin
                // wait for the last product to land in the accumulator
                if (!blend_busy)
                begin
                    res_next   = blend_result;
                    res_load   = 1'b1;
                    state_next = vts_pkg::ST_FINISH;
                end
            end
            vts_pkg::ST_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    out_load   = 1'b1;
                    state_next = vts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vts_pkg::ST_IDLE;
            end
        endcase

        result_valid_next = result_valid_reg;
        if (result_ready)
            result_valid_next = 1'b0;
        if (out_load)
            result_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= vts_pkg::ST_IDLE;
            corner_reg       <= '0;
            result_valid_reg <= 1'b0;
            size_x_reg       <= '0;
            size_y_reg       <= '0;
            size_z_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            corner_reg       <= corner_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    vts_pkg::CFG_SIZE_X: size_x_reg <= cfg_data;
                    vts_pkg::CFG_SIZE_Y: size_y_reg <= cfg_data;
                    vts_pkg::CFG_SIZE_Z: size_z_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            u_reg       <= coord_u;
            v_reg       <= coord_v;
            w_reg       <= coord_w;
            nearest_reg <= nearest;
        end
        if (state_reg == vts_pkg::ST_LOCATE)
        begin
            loc_x_reg <= loc_x;
            loc_y_reg <= loc_y;
            loc_z_reg <= loc_z;
        end
        if (res_load)
            res_reg <= res_next;
        if (out_load)
            sample_value_reg <= res_reg;
    end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for volume_trilinear_sampler_core. A queue-fed driver pushes
// voxel writes and samples under bursty traffic while the result side
// stalls on its own pattern. Each sample is predicted from a local copy of
// the volume and the size registers, then compared in order with the
// sample_value items that come back.
// ---------------------------------------------------------------------------
module tb_top;
    import vts_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int LIMIT_CYCLES = 500000;
    localparam int SETTLE       = 20;
    localparam int RAND_OPS     = 77;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int ONE_POS  = 1 << COORD_FRAC_BITS;
    localparam int HALF_POS = 1 << COORD_FRAC_BITS;
    localparam int FULL_W   = 1 << FRAC_W;
    localparam int BLEND_SH = 3 * FRAC_W;

    typedef struct {
        logic                         op;
        logic [DIM_BITS-1:0]          vx;
        logic [DIM_BITS-1:0]          vy;
        logic [DIM_BITS-1:0]          vz;
        logic signed [VALUE_BITS-1:0] val;
        logic signed [COORD_W-1:0]    cu;
        logic signed [COORD_W-1:0]    cv;
        logic signed [COORD_W-1:0]    cw;
        logic                         nn;
    } voxel_op_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         item_valid = 1'b0;
    logic                         item_ready;
    logic                         opcode = OP_WRITE;
    logic [DIM_BITS-1:0]          voxel_x = '0;
    logic [DIM_BITS-1:0]          voxel_y = '0;
    logic [DIM_BITS-1:0]          voxel_z = '0;
    logic signed [VALUE_BITS-1:0] voxel_value = '0;
    logic signed [COORD_W-1:0]    coord_u = '0;
    logic signed [COORD_W-1:0]    coord_v = '0;
    logic signed [COORD_W-1:0]    coord_w = '0;
    logic                         nearest = 1'b0;
    logic                         result_valid;
    logic                         result_ready = 1'b0;
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_INDEX_W-1:0]       cfg_index = '0;
    logic [SIZE_W-1:0]            cfg_data = '0;

    voxel_op_t                    pending_ops[$];
    logic signed [VALUE_BITS-1:0] expected_samples[$];
    logic signed [VALUE_BITS-1:0] volume_copy [VOXEL_COUNT];
    logic [SIZE_W-1:0]            size_x_reg = '0;
    logic [SIZE_W-1:0]            size_y_reg = '0;
    logic [SIZE_W-1:0]            size_z_reg = '0;

    logic item_fire = 1'b0;
    int   error_count = 0;
    int   cycle_count = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   hold_left = 0;
    int   ready_beat = 0;
    int   stall_style = 0;

    volume_trilinear_sampler_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .voxel_x      (voxel_x),
        .voxel_y      (voxel_y),
        .voxel_z      (voxel_z),
        .voxel_value  (voxel_value),
        .coord_u      (coord_u),
        .coord_v      (coord_v),
        .coord_w      (coord_w),
        .nearest      (nearest),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sample_value (sample_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int clip_size(input logic [SIZE_W-1:0] s);
        return (int'(s) > DIM_MAX) ? DIM_MAX : int'(s);
    endfunction

    // Map a Q2.14 coordinate to a base voxel and a 15-bit fraction.
    function automatic void locate_axis(input logic signed [COORD_W-1:0] c, input int s,
                                        output int base, output int frac);
        int a;
        int p;
        a = int'(c) + ONE_POS;
        if (a < 0)
            a = 0;
        if (a > 2 * ONE_POS)
            a = 2 * ONE_POS;
        p = a * (s - 1);
        base = p >> FRAC_W;
        if (base > s - 1)
            base = s - 1;
        frac = p - (base << FRAC_W);
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] sample_volume(
        input logic signed [COORD_W-1:0] cu,
        input logic signed [COORD_W-1:0] cv,
        input logic signed [COORD_W-1:0] cw,
        input logic nn);
        int     ext [3];
        int     lo [3];
        int     hi [3];
        int     frac [3];
        int     xi, yi, zi;
        longint wx, wy, wz;
        longint acc;
        ext[0] = clip_size(size_x_reg);
        ext[1] = clip_size(size_y_reg);
        ext[2] = clip_size(size_z_reg);
        if (ext[0] == 0 || ext[1] == 0 || ext[2] == 0)
            return '0;
        locate_axis(cu, ext[0], lo[0], frac[0]);
        locate_axis(cv, ext[1], lo[1], frac[1]);
        locate_axis(cw, ext[2], lo[2], frac[2]);
        if (nn)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                if (frac[ax] >= HALF_POS && lo[ax] + 1 < ext[ax])
                    lo[ax] = lo[ax] + 1;
            end
            return volume_copy[lo[0] + DIM_MAX * (lo[1] + DIM_MAX * lo[2])];
        end
        for (int ax = 0; ax < 3; ax++)
            hi[ax] = (lo[ax] + 1 < ext[ax]) ? lo[ax] + 1 : ext[ax] - 1;
        acc = 0;
        for (int a = 0; a < 2; a++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    xi = a ? hi[0] : lo[0];
                    yi = b ? hi[1] : lo[1];
                    zi = k ? hi[2] : lo[2];
                    wx = a ? longint'(frac[0]) : longint'(FULL_W - frac[0]);
                    wy = b ? longint'(frac[1]) : longint'(FULL_W - frac[1]);
                    wz = k ? longint'(frac[2]) : longint'(FULL_W - frac[2]);
                    acc += longint'(volume_copy[xi + DIM_MAX * (yi + DIM_MAX * zi)])
                           * wx * wy * wz;
                end
            end
        end
        // round to nearest, ties toward plus infinity
        acc = (acc + (longint'(1) <<< (BLEND_SH - 1))) >>> BLEND_SH;
        return acc[VALUE_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Item driver: bursts with random gaps
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : feed_items
        voxel_op_t op;
        if (rst_n && !(item_valid && !item_fire))
        begin
            if (gap_left != 0)
            begin
                gap_left   <= gap_left - 1;
                item_valid <= 1'b0;
            end
            else if (pending_ops.size() != 0)
            begin
                op = pending_ops.pop_front();
                item_valid  <= 1'b1;
                opcode      <= op.op;
                voxel_x     <= op.vx;
                voxel_y     <= op.vy;
                voxel_z     <= op.vz;
                voxel_value <= op.val;
                coord_u     <= op.cu;
                coord_v     <= op.cv;
                coord_w     <= op.cw;
                nearest     <= op.nn;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    if ($urandom_range(15) == 0)
                        gap_left <= 30;
                    else if ($urandom_range(2) == 0)
                        gap_left <= 0;
                    else
                        gap_left <= $urandom_range(1, 8);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: stall pattern chosen per phase, plus occasional holds
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        ready_beat <= ready_beat + 1;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            case (stall_style)
                0:       result_ready <= 1'b1;
                1:       result_ready <= ($urandom_range(3) != 0);
                default: result_ready <= ((ready_beat % 5) < 3);
            endcase
            if ($urandom_range(63) == 0)
                hold_left <= $urandom_range(4, 16);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: track accepted items, check results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        logic signed [VALUE_BITS-1:0] want;
        item_fire <= item_valid && item_ready;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                if (opcode == OP_WRITE)
                    volume_copy[{voxel_z, voxel_y, voxel_x}] = voxel_value;
                else
                    expected_samples.push_back(sample_volume(coord_u, coord_v, coord_w,
                                                             nearest));
            end
            if (result_valid && result_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: sample_value %0d with no sample pending", $time,
                             sample_value);
                    error_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample_value !== want)
                    begin
                        $display("%0t: sample_value expected %0d actual %0d", $time,
                                 want, sample_value);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SIZE_X: size_x_reg = val;
            CFG_SIZE_Y: size_y_reg = val;
            CFG_SIZE_Z: size_z_reg = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every item is taken and every sample has come back.
    task automatic wait_drained();
        while (pending_ops.size() != 0 || item_valid || expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return ($urandom_range(1) != 0) ? 16'sh0000 : 16'shFFFF;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        int r;
        case ($urandom_range(9))
            6:       r = int'($urandom);
            7:
            begin
                case ($urandom_range(3))
                    0:       r = -32768;
                    1:       r = 32767;
                    2:       r = -ONE_POS;
                    default: r = ONE_POS;
                endcase
            end
            8, 9:    r = int'($urandom_range(0, 64)) - 32;
            default: r = int'($urandom_range(0, 2 * ONE_POS)) - ONE_POS;
        endcase
        return r[COORD_W-1:0];
    endfunction

    function automatic voxel_op_t make_write(input int x, input int y, input int z,
                                             input logic signed [VALUE_BITS-1:0] v);
        voxel_op_t op;
        op.op  = OP_WRITE;
        op.vx  = x[DIM_BITS-1:0];
        op.vy  = y[DIM_BITS-1:0];
        op.vz  = z[DIM_BITS-1:0];
        op.val = v;
        op.cu  = COORD_W'($urandom);
        op.cv  = COORD_W'($urandom);
        op.cw  = COORD_W'($urandom);
        op.nn  = 1'($urandom);
        return op;
    endfunction

    function automatic voxel_op_t make_sample(input int u, input int v, input int w,
                                              input logic nn);
        voxel_op_t op;
        op     = make_write($urandom, $urandom, $urandom, VALUE_BITS'($urandom));
        op.op  = OP_SAMPLE;
        op.cu  = u[COORD_W-1:0];
        op.cv  = v[COORD_W-1:0];
        op.cw  = w[COORD_W-1:0];
        op.nn  = nn;
        return op;
    endfunction

    function automatic voxel_op_t random_op(input int ex, input int ey, input int ez);
        voxel_op_t op;
        if ($urandom_range(3) == 0)
        begin
            if (ex * ey * ez != 0 && $urandom_range(4) < 3)
                op = make_write($urandom_range(0, ex - 1), $urandom_range(0, ey - 1),
                                $urandom_range(0, ez - 1), pick_value());
            else
                op = make_write($urandom, $urandom, $urandom, pick_value());
        end
        else
        begin
            op = make_sample(pick_coord(), pick_coord(), pick_coord(), 1'($urandom));
        end
        return op;
    endfunction

    // Set sizes, load every voxel that a sample can reach, then mixed traffic.
    task automatic run_phase(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                             input logic [SIZE_W-1:0] sz, input int n_random);
        int ex, ey, ez;
        wait_drained();
        stall_style = $urandom_range(2);
        write_reg(CFG_SIZE_X, sx);
        write_reg(CFG_SIZE_Y, sy);
        write_reg(CFG_SIZE_Z, sz);
        ex = clip_size(sx);
        ey = clip_size(sy);
        ez = clip_size(sz);
        if (ex * ey * ez != 0)
        begin
            for (int z = 0; z < ez; z++)
                for (int y = 0; y < ey; y++)
                    for (int x = 0; x < ex; x++)
                        pending_ops.push_back(make_write(x, y, z, pick_value()));
        end
        repeat (n_random) pending_ops.push_back(random_op(ex, ey, ez));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty volume straight out of reset
        pending_ops.push_back(make_sample(0, 0, 0, 1'b0));
        pending_ops.push_back(make_sample(-32768, 32767, 0, 1'b1));

        wait_drained();
        write_reg(CFG_SIZE_X, 6'd2);
        write_reg(CFG_SIZE_Y, 6'd2);
        write_reg(CFG_SIZE_Z, 6'd2);
        pending_ops.push_back(make_write(0, 0, 0, 16'sh7FFF));
        pending_ops.push_back(make_write(1, 0, 0, 16'sh8000));
        pending_ops.push_back(make_write(0, 1, 0, 16'sh0000));
        pending_ops.push_back(make_write(1, 1, 0, 16'shFFFF));
        pending_ops.push_back(make_write(0, 0, 1, 16'sh0100));
        pending_ops.push_back(make_write(1, 0, 1, -16'sh0100));
        pending_ops.push_back(make_write(0, 1, 1, 16'sh0080));
        pending_ops.push_back(make_write(1, 1, 1, 16'sh1234));
        pending_ops.push_back(make_write(31, 31, 31, 16'sh5A5A));
        // corners, clamping, exact half and just below half
        pending_ops.push_back(make_sample(-ONE_POS, -ONE_POS, -ONE_POS, 1'b1));
        pending_ops.push_back(make_sample(ONE_POS, ONE_POS, ONE_POS, 1'b1));
        pending_ops.push_back(make_sample(-32768, -32768, -32768, 1'b0));
        pending_ops.push_back(make_sample(32767, 32767, 32767, 1'b0));
        pending_ops.push_back(make_sample(32767, -32768, 32767, 1'b1));
        pending_ops.push_back(make_sample(0, 0, 0, 1'b1));
        pending_ops.push_back(make_sample(-1, -1, -1, 1'b1));
        pending_ops.push_back(make_sample(0, 0, 0, 1'b0));
        pending_ops.push_back(make_sample(0, -ONE_POS, ONE_POS, 1'b0));
        pending_ops.push_back(make_sample(8192, -8192, 1, 1'b0));

        run_phase(6'd3, 6'd3, 6'd3, RAND_OPS);
        run_phase(6'd4, 6'd4, 6'd4, RAND_OPS);
        run_phase(6'd63, 6'd2, 6'd1, RAND_OPS);
        wait_drained();
        write_reg(CFG_UNUSED, 6'd42);
        run_phase(6'd1, 6'd33, 6'd1, RAND_OPS);
        run_phase(6'd2, 6'd1, 6'd32, RAND_OPS);
        run_phase(6'd0, 6'd5, 6'd5, RAND_OPS / 2);
        run_phase(6'd7, 6'd0, 6'd3, RAND_OPS / 2);
        run_phase(6'd5, 6'd4, 6'd3, RAND_OPS);
        run_phase(6'd1, 6'd1, 6'd1, RAND_OPS);
        run_phase(6'd32, 6'd2, 6'd1, RAND_OPS);
        run_phase(6'd3, 6'd5, 6'd63, RAND_OPS);

        wait_drained();
        if (expected_samples.size() != 0)
            $display("%0t: %0d samples never returned", $time, expected_samples.size());
        if (error_count == 0 && expected_samples.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
